/* rtl/qach_pkg.sv */
// shared types, constants and helpers for the quote-aware character histogram
package qach_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int COUNT_W1 = COUNT_WIDTH + 1;
	localparam int NUM_BINS = 256;
	localparam int QUEUE_DEPTH = 4;

	typedef logic [COUNT_WIDTH-1:0] cnt_t;
	localparam cnt_t CNT_MAX = '1;

	typedef enum logic [1:0] {
		REQ_DATA    = 2'd0,
		REQ_END     = 2'd1,
		REQ_READ    = 2'd2,
		REQ_RESTART = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		REG_LINE_LIMIT  = 3'd0,
		REG_SKIP_LINES  = 3'd1,
		REG_COMMENT     = 3'd2,
		REG_QUOTE       = 3'd3,
		REG_ESCAPE_MODE = 3'd4,
		REG_INCLUDE     = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_BUMP  = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} op_kind_t;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_DIG_LO = 8'h30;
	localparam logic [7:0] CH_DIG_HI = 8'h39;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_Z   = 8'h5A;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_Z   = 8'h7A;

	localparam logic [15:0] LINE_LIMIT_RST = 16'd30;
	localparam logic [15:0] LINES_MAX = 16'hFFFF;

	typedef struct packed {
		logic [15:0] line_limit;
		logic [15:0] skip_lines;
		logic [7:0]  comment_char;
		logic [7:0]  quote_char;
		logic [1:0]  escape_mode;
		logic [2:0]  include_classes;
	} cfg_t;

	// one queued command from the classifier to the histogram side
	typedef struct packed {
		op_kind_t    kind;
		logic [7:0]  bin;
		logic [1:0]  bs_add;
		logic        done;
	} op_t;

	function automatic logic [31:0] sat32(cnt_t v);
		logic [63:0] w;
		w = 64'(v);
		return (w > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
	endfunction

	function automatic cnt_t sat_add(cnt_t v, logic [1:0] inc);
		logic [COUNT_W1-1:0] sum;
		sum = {1'b0, v} + COUNT_W1'(inc);
		return (sum > {1'b0, CNT_MAX}) ? CNT_MAX : sum[COUNT_WIDTH-1:0];
	endfunction

endpackage

/* rtl/qach_ram.sv */
// generic single write port ram with registered read
module qach_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/qach_front.sv */
// front end: takes request words, tracks quote/comment/line state, emits histogram ops
module qach_front import qach_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [1:0] req_type,
	input  logic [7:0] byte_value,
	input  logic [7:0] symbol,
	input  cfg_t       cfg,
	output logic       push,
	output op_t        op
);

	typedef struct packed {
		logic        in_quote;
		logic        pend_quote;
		logic        pend_bslash;
		logic        in_comment;
		logic        stopped;
		logic [15:0] lines_skipped;
		logic [15:0] lines_counted;
	} fst_t;

	typedef struct packed {
		fst_t       st;
		logic       bump;
		logic [7:0] bin;
		logic [1:0] bs_add;
	} step_t;

	fst_t  fst_q;
	step_t nx;

	function automatic logic class_dropped(logic [7:0] x, logic [2:0] incl);
		logic letter, digit, blank;
		letter = x inside {[CH_LO_A:CH_LO_Z], [CH_UP_A:CH_UP_Z]};
		digit  = x inside {[CH_DIG_LO:CH_DIG_HI]};
		blank  = x inside {CH_SPACE, CH_TAB, CH_CR};
		return (!incl[0] && letter) || (!incl[1] && digit) || (!incl[2] && blank);
	endfunction

	// byte outside quotes that may be counted
	function automatic step_t do_plain(step_t s, logic [7:0] x, cfg_t c);
		step_t r;
		r = s;
		if (c.comment_char != CH_NUL && x == c.comment_char) begin
			r.st.in_comment = 1'b1;
		end else if (!class_dropped(x, c.include_classes)) begin
			if (x == CH_BSLASH) begin
				r.bs_add = r.bs_add + 2'd1;
			end else begin
				r.bump = 1'b1;
				r.bin  = x;
			end
			if (x == CH_NL && r.st.lines_counted != LINES_MAX) begin
				r.st.lines_counted = r.st.lines_counted + 16'd1;
			end
			if (r.st.lines_counted >= c.line_limit) begin
				r.st.stopped = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic step_t do_normal(step_t s, logic [7:0] x, cfg_t c);
		step_t r;
		r = s;
		if (!r.st.stopped) begin
			if (r.st.lines_skipped < c.skip_lines) begin
				if (x == CH_NL) begin
					r.st.lines_skipped = r.st.lines_skipped + 16'd1;
				end
			end else if (r.st.in_comment) begin
				if (x == CH_NL) begin
					r.st.in_comment = 1'b0;
				end
			end else if (x == CH_NUL) begin
				r.st.stopped = 1'b1;
			end else if (c.quote_char != CH_NUL && x == c.quote_char) begin
				if (c.escape_mode[1]) begin
					r.st.pend_quote = 1'b1;
				end else begin
					r.st.in_quote = !r.st.in_quote;
				end
			end else if (c.escape_mode[0] && x == CH_BSLASH) begin
				r.st.pend_bslash = 1'b1;
			end else if (!r.st.in_quote) begin
				r = do_plain(r, x, c);
			end
		end
		return r;
	endfunction

	always_comb begin
		nx.st     = fst_q;
		nx.bump   = 1'b0;
		nx.bin    = byte_value;
		nx.bs_add = 2'd0;
		op.kind   = OP_NONE;
		op.bin    = byte_value;
		case (req_t'(req_type))
			REQ_DATA: begin
				if (!fst_q.stopped) begin
					if (fst_q.pend_bslash) begin
						// escaped pair: both bytes count whatever their class
						nx.st.pend_bslash = 1'b0;
						if (byte_value == CH_BSLASH) begin
							nx.bs_add = 2'd2;
						end else begin
							nx.bs_add = 2'd1;
							nx.bump   = 1'b1;
						end
					end else if (fst_q.pend_quote && byte_value == cfg.quote_char &&
							cfg.escape_mode[0] && cfg.quote_char == CH_BSLASH) begin
						nx.st.pend_quote = 1'b0;
						nx.bs_add        = 2'd2;
					end else begin
						if (fst_q.pend_quote) begin
							nx.st.pend_quote = 1'b0;
							if (byte_value != cfg.quote_char) begin
								nx.st.in_quote = !fst_q.in_quote;
							end else if (!fst_q.in_quote) begin
								nx = do_plain(nx, cfg.quote_char, cfg);
							end
						end
						nx = do_normal(nx, byte_value, cfg);
					end
				end
				op.kind = nx.bump ? OP_BUMP : OP_NONE;
				op.bin  = nx.bin;
			end
			REQ_END: begin
				if (!fst_q.stopped) begin
					if (fst_q.pend_quote) begin
						nx.st.in_quote = !fst_q.in_quote;
					end
					nx.st.pend_quote  = 1'b0;
					nx.st.pend_bslash = 1'b0;
					nx.st.stopped     = 1'b1;
				end
			end
			REQ_READ: begin
				op.kind = OP_READ;
				op.bin  = symbol;
			end
			REQ_RESTART: begin
				nx.st   = '0;
				op.kind = OP_CLEAR;
			end
			default: begin
				op.kind = OP_NONE;
			end
		endcase
		op.bs_add = nx.bs_add;
		op.done   = nx.st.stopped;
	end

	assign push = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fst_q <= '0;
		end else if (push) begin
			fst_q <= nx.st;
		end
	end

endmodule

/* rtl/qach_queue.sv */
// short fifo of ops between classifier and histogram side
module qach_queue import qach_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	input  logic pop,
	output op_t  head_op,
	output logic empty,
	output logic full
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	op_t              entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [PTR_W:0]   fill_q;

	assign empty   = (fill_q == '0);
	assign full    = (fill_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign head_op = entry_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/qach_back.sv */
// back end: histogram ram read-modify-write, count reads and the output register
module qach_back import qach_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  op_t         head_op,
	input  logic        q_empty,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] count,
	output logic        done_res
);

	localparam int BIN_W = $clog2(NUM_BINS);

	logic                valid_s1;
	op_t                 op_s1;
	logic [NUM_BINS-1:0] hvalid_q;
	cnt_t                bs_q;
	logic                wr_vld_q;
	logic [BIN_W-1:0]    wr_addr_q;
	cnt_t                wr_data_q;
	logic                out_valid_q;
	logic [31:0]         count_q;
	logic                done_q;

	logic       adv;
	logic       we;
	cnt_t       rdata;
	cnt_t       cur;
	cnt_t       bumped;
	logic [31:0] rd_count;

	assign adv = valid_s1 && (!out_valid_q || !out_stall);
	assign pop = !q_empty && (!valid_s1 || adv);
	assign we  = adv && (op_s1.kind == OP_BUMP);

	qach_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (NUM_BINS)
	) u_hist (
		.clk   (clk),
		.we    (we),
		.waddr (op_s1.bin),
		.wdata (bumped),
		.re    (pop),
		.raddr (head_op.bin),
		.rdata (rdata)
	);

	// the previous write lands the same cycle this entry's read was issued
	always_comb begin
		if (wr_vld_q && wr_addr_q == op_s1.bin) begin
			cur = wr_data_q;
		end else if (hvalid_q[op_s1.bin]) begin
			cur = rdata;
		end else begin
			cur = '0;
		end
		bumped   = (cur == CNT_MAX) ? cur : cur + 1'b1;
		rd_count = (op_s1.bin == CH_BSLASH) ? sat32(bs_q) : sat32(cur);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			hvalid_q    <= '0;
			bs_q        <= '0;
			wr_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
				if (op_s1.kind == OP_CLEAR) begin
					hvalid_q <= '0;
					bs_q     <= '0;
					wr_vld_q <= 1'b0;
				end else begin
					bs_q <= sat_add(bs_q, op_s1.bs_add);
					if (op_s1.kind == OP_BUMP) begin
						hvalid_q[op_s1.bin] <= 1'b1;
						wr_vld_q            <= 1'b1;
					end
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_s1 <= head_op;
		end
		if (we) begin
			wr_addr_q <= op_s1.bin;
			wr_data_q <= bumped;
		end
		if (adv) begin
			count_q <= (op_s1.kind == OP_READ) ? rd_count : 32'd0;
			done_q  <= op_s1.done;
		end
	end

	assign out_valid = out_valid_q;
	assign count     = count_q;
	assign done_res  = done_q;

endmodule

/* rtl/quote_aware_char_histogram_core.sv */
// Quote-aware byte histogram core. One request word is taken per clock and one result word
// is returned per request, in order; throughput is one word per cycle as long as the output
// side keeps up. A taken word is written into a queue slot at the edge that takes it, then
// passes through the histogram ram read stage and then the output register, which holds
// its result word. The rate is set by the single read-modify-write of
// the 256-entry histogram ram per word, with the last write forwarded so repeated bytes run
// back to back; backslash counts live in a separate register so an escaped pair needs only
// one ram update. Restart clears the histogram at once through per-bin valid bits, with no
// clearing pass. A four-entry queue sits between the classifier and the histogram side.
// Configuration registers may only be written while no request is in flight.
module quote_aware_char_histogram_core import qach_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [7:0]  byte_value,
	input  logic [7:0]  symbol,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] count,
	output logic        done_res,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t cfg_q;
	logic push;
	op_t  push_op;
	op_t  head_op;
	logic q_empty;
	logic q_full;
	logic pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_limit      <= LINE_LIMIT_RST;
			cfg_q.skip_lines      <= '0;
			cfg_q.comment_char    <= CH_NUL;
			cfg_q.quote_char      <= CH_DQUOTE;
			cfg_q.escape_mode     <= '0;
			cfg_q.include_classes <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_LINE_LIMIT:  cfg_q.line_limit      <= cfg_data;
				REG_SKIP_LINES:  cfg_q.skip_lines      <= cfg_data;
				REG_COMMENT:     cfg_q.comment_char    <= cfg_data[7:0];
				REG_QUOTE:       cfg_q.quote_char      <= cfg_data[7:0];
				REG_ESCAPE_MODE: cfg_q.escape_mode     <= cfg_data[1:0];
				REG_INCLUDE:     cfg_q.include_classes <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	assign in_stall = q_full;

	qach_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.byte_value (byte_value),
		.symbol     (symbol),
		.cfg        (cfg_q),
		.push       (push),
		.op         (push_op)
	);

	qach_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head_op (head_op),
		.empty   (q_empty),
		.full    (q_full)
	);

	qach_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_op   (head_op),
		.q_empty   (q_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.count     (count),
		.done_res  (done_res)
	);

endmodule

/* rtl/qach_checker.sv */
// port-level checker for the histogram core, bound to the top level
module qach_checker import qach_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] count,
	input logic        done_res
);

	// words taken but not yet delivered: queue, ram stage, output register
	localparam int MAX_INFLIGHT = QUEUE_DEPTH + 2;
	localparam int INF_W = $clog2(MAX_INFLIGHT + 2);

	logic [INF_W-1:0] inflight_q;
	logic             in_acc;
	logic             out_acc;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_acc && !out_acc) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(count) && $stable(done_res))
		else $error("stalled result word changed or dropped");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != '0)
		else $error("result word with no request outstanding");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= INF_W'(MAX_INFLIGHT))
		else $error("more words in flight than the pipeline holds");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> inflight_q >= INF_W'(QUEUE_DEPTH))
		else $error("input stalled while the queue has room");

endmodule

bind quote_aware_char_histogram_core qach_checker u_qach_checker (.*);

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// self-checking testbench for the quote-aware character histogram core
module testbench;
	import qach_pkg::*;

	localparam int unsigned LIMIT_CYCLES = 400000;
	localparam int unsigned HOLD_CYCLES = 150;

	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_MAXB   = 8'hFF;

	typedef struct packed {
		logic [31:0] count;
		logic        done;
	} hist_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  req_type = REQ_DATA;
	logic [7:0]  byte_value = '0;
	logic [7:0]  symbol = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] count;
	logic        done_res;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = REG_LINE_LIMIT;
	logic [15:0] cfg_data = '0;

	int unsigned send_pct = 12;
	int unsigned recv_pct = 55;
	int unsigned hold_len = 0;
	int unsigned hold_req = 0;
	int unsigned hold_ack = 0;
	int unsigned cycles = 0;
	int          errors = 0;

	hist_result_t due_results [$];

	// mirror of the block state and its registers
	cnt_t        tally [NUM_BINS];
	logic        quoted, quote_held, escape_held, commented, halted;
	logic [15:0] skipped_lines, counted_lines;
	logic [15:0] lim_reg, skip_reg;
	logic [7:0]  cmt_reg, quote_reg;
	logic [1:0]  esc_reg;
	logic [2:0]  incl_reg;

	quote_aware_char_histogram_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.byte_value (byte_value),
		.symbol     (symbol),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.count      (count),
		.done_res   (done_res),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic void clear_counts();
		foreach (tally[i]) tally[i] = '0;
		quoted = 1'b0;
		quote_held = 1'b0;
		escape_held = 1'b0;
		commented = 1'b0;
		halted = 1'b0;
		skipped_lines = '0;
		counted_lines = '0;
	endfunction

	function automatic void bump_bin(logic [7:0] c);
		if (tally[c] != CNT_MAX)
			tally[c] = tally[c] + 1'b1;
	endfunction

	function automatic void count_plain(logic [7:0] c);
		logic letter, digit, blank;
		letter = (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
		digit = (c >= CH_DIG_LO && c <= CH_DIG_HI);
		blank = (c == CH_SPACE || c == CH_TAB || c == CH_CR);
		if (cmt_reg != CH_NUL && c == cmt_reg) begin
			commented = 1'b1;
			return;
		end
		if ((letter && !incl_reg[0]) || (digit && !incl_reg[1]) || (blank && !incl_reg[2]))
			return;
		bump_bin(c);
		if (c == CH_NL && counted_lines != LINES_MAX)
			counted_lines++;
		if (counted_lines >= lim_reg)
			halted = 1'b1;
	endfunction

	function automatic void count_normal(logic [7:0] c);
		if (halted)
			return;
		if (skipped_lines < skip_reg) begin
			if (c == CH_NL)
				skipped_lines++;
			return;
		end
		if (commented) begin
			if (c == CH_NL)
				commented = 1'b0;
			return;
		end
		if (c == CH_NUL) begin
			halted = 1'b1;
			return;
		end
		if (quote_reg != CH_NUL && c == quote_reg) begin
			if (esc_reg[1])
				quote_held = 1'b1;
			else
				quoted = !quoted;
		end else if (esc_reg[0] && c == CH_BSLASH) begin
			escape_held = 1'b1;
		end else if (!quoted) begin
			count_plain(c);
		end
	endfunction

	// resolve a held quote or backslash with the new byte first
	function automatic void count_data(logic [7:0] c);
		if (halted)
			return;
		if (escape_held) begin
			escape_held = 1'b0;
			bump_bin(CH_BSLASH);
			bump_bin(c);
			return;
		end
		if (quote_held) begin
			quote_held = 1'b0;
			if (c != quote_reg) begin
				quoted = !quoted;
			end else if (esc_reg[0] && quote_reg == CH_BSLASH) begin
				bump_bin(CH_BSLASH);
				bump_bin(c);
				return;
			end else if (!quoted) begin
				count_plain(quote_reg);
			end
		end
		count_normal(c);
	endfunction

	function automatic hist_result_t histogram_step(req_t req, logic [7:0] b, logic [7:0] sym);
		hist_result_t r;
		logic [63:0]  wide;
		r.count = '0;
		case (req)
			REQ_DATA: count_data(b);
			REQ_END: begin
				if (!halted) begin
					if (quote_held)
						quoted = !quoted;
					quote_held = 1'b0;
					escape_held = 1'b0;
					halted = 1'b1;
				end
			end
			REQ_READ: begin
				wide = 64'(tally[sym]);
				r.count = (wide > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
			end
			default: clear_counts();
		endcase
		r.done = halted;
		return r;
	endfunction

	function automatic logic [7:0] pick_text_byte();
		int unsigned r;
		r = $urandom_range(999);
		if (r < 200) begin
			case ($urandom_range(3))
				0: return CH_COMMA;
				1: return CH_SEMI;
				2: return CH_PIPE;
				default: return CH_TAB;
			endcase
		end
		if (r < 430)
			return $urandom_range(1) ? 8'($urandom_range(CH_LO_Z, CH_LO_A))
				: 8'($urandom_range(CH_UP_Z, CH_UP_A));
		if (r < 540)
			return 8'($urandom_range(CH_DIG_HI, CH_DIG_LO));
		if (r < 600)
			return $urandom_range(1) ? CH_SPACE : CH_CR;
		if (r < 690)
			return (quote_reg != CH_NUL) ? quote_reg : CH_DQUOTE;
		if (r < 730)
			return CH_BSLASH;
		if (r < 840)
			return CH_NL;
		if (r < 870)
			return (cmt_reg != CH_NUL) ? cmt_reg : CH_HASH;
		if (r < 875)
			return CH_NUL;
		return 8'($urandom_range(255));
	endfunction

	// one request word; prediction is made at the edge that takes it
	task automatic send_word(req_t req, logic [7:0] b, logic [7:0] sym);
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		byte_value <= b;
		symbol <= sym;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		due_results.push_back(histogram_step(req, b, sym));
	endtask

	task automatic send_data(logic [7:0] b);
		send_word(REQ_DATA, b, 8'($urandom_range(255)));
	endtask

	task automatic send_read(logic [7:0] sym);
		send_word(REQ_READ, 8'($urandom_range(255)), sym);
	endtask

	task automatic send_ctl(req_t req);
		send_word(req, 8'($urandom_range(255)), 8'($urandom_range(255)));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [15:0] lim, input logic [15:0] skip,
			input logic [7:0] cmt, input logic [7:0] q, input logic [1:0] esc,
			input logic [2:0] incl);
		wait_idle();
		write_reg(REG_LINE_LIMIT, lim);
		write_reg(REG_SKIP_LINES, skip);
		write_reg(REG_COMMENT, 16'(cmt));
		write_reg(REG_QUOTE, 16'(q));
		write_reg(REG_ESCAPE_MODE, 16'(esc));
		write_reg(REG_INCLUDE, 16'(incl));
		cfg_we <= 1'b0;
		lim_reg = lim;
		skip_reg = skip;
		cmt_reg = cmt;
		quote_reg = q;
		esc_reg = esc;
		incl_reg = incl;
	endtask

	// reset register values, quoted field, zero byte stop, words after stop, restart
	task automatic test_defaults_and_stop();
		send_data(CH_MAXB);
		send_data(CH_COMMA);
		send_data(CH_DQUOTE);
		send_data(CH_SEMI);
		send_data(CH_DQUOTE);
		send_read(CH_MAXB);
		send_read(CH_COMMA);
		send_data(CH_NUL);
		send_data(CH_COMMA);
		send_ctl(REQ_END);
		send_read(CH_COMMA);
		send_ctl(REQ_RESTART);
		send_read(CH_NUL);
	endtask

	// skipped line, comment line, doubled quote, escaped newline, held quote at end
	task automatic test_skip_comment_escape();
		set_config(16'd2, 16'd1, CH_HASH, CH_DQUOTE, 2'd3, 3'd7);
		send_ctl(REQ_RESTART);
		send_data(CH_NL);
		send_data(CH_HASH);
		send_data(CH_COMMA);
		send_data(CH_NL);
		send_data(CH_DQUOTE);
		send_data(CH_DQUOTE);
		send_data(CH_BSLASH);
		send_data(CH_NL);
		send_data(CH_DQUOTE);
		send_ctl(REQ_END);
		send_read(CH_DQUOTE);
		send_read(CH_BSLASH);
	endtask

	// backslash as quote and comment, doubled with both escape bits, zero line limit
	task automatic test_quote_is_backslash();
		set_config(16'd0, 16'd0, CH_BSLASH, CH_BSLASH, 2'd3, 3'd0);
		send_ctl(REQ_RESTART);
		send_data(CH_BSLASH);
		send_data(CH_BSLASH);
		send_data(CH_COMMA);
		send_read(CH_BSLASH);
	endtask

	// receiver holds off long enough for the core to fill and stall its input
	task automatic test_backpressure();
		int unsigned saved_pct;
		saved_pct = send_pct;
		set_config(16'hFFFF, 16'd0, CH_NUL, CH_DQUOTE, 2'd0, 3'd7);
		send_ctl(REQ_RESTART);
		send_pct = 0;
		hold_req = hold_req + 1;
		repeat (40) begin
			if ($urandom_range(3) == 0)
				send_read(pick_text_byte());
			else
				send_data(pick_text_byte());
		end
		wait_idle();
		send_pct = saved_pct;
	endtask

	task automatic test_random_stream(int unsigned s_pct, int unsigned r_pct, int phases);
		int unsigned n, sent, r;
		logic [15:0] lim, skip;
		logic [7:0]  cmt, q;
		send_pct = s_pct;
		recv_pct = r_pct;
		for (int p = 0; p < phases; p++) begin
			case ($urandom_range(9))
				0: lim = 16'd0;
				1: lim = 16'hFFFF;
				2: lim = 16'd1;
				default: lim = 16'($urandom_range(30, 4));
			endcase
			case ($urandom_range(9))
				0: skip = 16'hFFFF;
				1, 2: skip = 16'($urandom_range(3, 1));
				default: skip = 16'd0;
			endcase
			case ($urandom_range(3))
				0: cmt = CH_NUL;
				1: cmt = CH_HASH;
				2: cmt = 8'($urandom_range(255));
				default: cmt = CH_MAXB;
			endcase
			case ($urandom_range(5))
				0: q = CH_NUL;
				1, 2: q = CH_DQUOTE;
				3: q = CH_SQUOTE;
				4: q = CH_BSLASH;
				default: q = 8'($urandom_range(255));
			endcase
			if ($urandom_range(7) == 0)
				cmt = q;
			set_config(lim, skip, cmt, q, 2'($urandom_range(3)), 3'($urandom_range(7)));
			send_ctl(REQ_RESTART);
			n = $urandom_range(110, 80);
			sent = 0;
			while (sent < n) begin
				r = $urandom_range(99);
				if (halted && r < 25) begin
					send_ctl(REQ_RESTART);
					sent++;
				end else if (r < 78) begin
					// bytes after a stop are dropped and do not count
					if (!halted)
						sent++;
					send_data(pick_text_byte());
				end else if (r < 91) begin
					sent++;
					send_read($urandom_range(1) ? pick_text_byte() : 8'($urandom_range(255)));
				end else if (r < 93) begin
					sent++;
					send_ctl(REQ_END);
				end else if (r < 95) begin
					sent++;
					send_ctl(REQ_RESTART);
				end else begin
					if (!halted)
						sent++;
					send_data(8'($urandom_range(255)));
				end
			end
			send_ctl(REQ_END);
			repeat (6) send_read(pick_text_byte());
		end
	endtask

	// takes one result word per accepting edge
	always @(posedge clk) begin : check_results
		hist_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (due_results.size() == 0) begin
				$error("result word with nothing expected: count %0d done_res %0b",
					count, done_res);
				errors++;
			end else begin
				e = due_results.pop_front();
				if (count !== e.count) begin
					$error("count mismatch: expected %0d, got %0d", e.count, count);
					errors++;
				end
				if (done_res !== e.done) begin
					$error("done_res mismatch: expected %0b, got %0b", e.done, done_res);
					errors++;
				end
			end
		end
	end

	// a long hold-off starts whenever a new hold request shows up
	always @(posedge clk) begin
		if (hold_ack != hold_req) begin
			hold_ack <= hold_req;
			hold_len <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_len != 0) begin
			out_stall <= 1'b1;
			hold_len <= hold_len - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("[quote_aware_char_histogram_core] ERROR");
			$finish;
		end
	end

	initial begin
		lim_reg = LINE_LIMIT_RST;
		skip_reg = '0;
		cmt_reg = CH_NUL;
		quote_reg = CH_DQUOTE;
		esc_reg = '0;
		incl_reg = '0;
		clear_counts();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults_and_stop();
		test_skip_comment_escape();
		test_quote_is_backslash();
		test_backpressure();
		test_random_stream(12, 55, 6);
		test_random_stream(55, 12, 6);
		test_random_stream(0, 0, 6);
		wait_idle();
		repeat (8) @(posedge clk);
		if (errors == 0 && due_results.size() == 0)
			$display("[quote_aware_char_histogram_core] OK");
		else
			$display("[quote_aware_char_histogram_core] ERROR");
		$finish;
	end

endmodule
